FILE: hdl/dlt_pkg.sv
// Shared widths, reset values and the seconds-to-minutes split for the lap timer.
`default_nettype none
package dlt_pkg;

	localparam int TimeW  = 32;
	localparam int CountW = 5;
	localparam int LimitW = 5;
	localparam int GapW   = 4;
	localparam int MinW   = 7;
	localparam int SecW   = 6;

	localparam logic [LimitW-1:0] LimitReset = 5'd15;
	localparam logic [GapW-1:0]   GapReset   = 4'd1;
	localparam logic [CountW-1:0] CountTop   = 5'd31;

	localparam int SecPerMin = 60;
	localparam int MinCap    = 99;
	// first time value whose minutes saturate
	localparam logic [TimeW-1:0] SatTime = TimeW'(MinCap * SecPerMin + SecPerMin);
	// 2^20 / 60 rounded up; exact for t < SatTime
	localparam logic [27:0] RecipSixty = 28'd17477;

	localparam logic CfgLapLimit = 1'b0;
	localparam logic CfgDebounce = 1'b1;

	localparam logic OpPress = 1'b0;
	localparam logic OpQuery = 1'b1;

	typedef struct packed {
		logic [MinW-1:0] minutes;
		logic [SecW-1:0] seconds;
	} split_t;

	// t % 60 = 4 * ((t >> 2) % 15) + t % 4; mod 15 by nibble sums
	function automatic split_t split_time(input logic [TimeW-1:0] t);
		logic [31:0] qx;
		logic [6:0]  nsum;
		logic [4:0]  fold;
		logic [3:0]  r15;
		logic [27:0] prod;
		split_t      res;
		qx   = {2'b00, t[TimeW-1:2]};
		nsum = '0;
		for (int i = 0; i < 8; i++) begin
			nsum = nsum + 7'(qx[4*i +: 4]);
		end
		fold = 5'(nsum[6:4]) + 5'(nsum[3:0]);
		if (fold >= 5'd15) begin
			r15 = 4'(fold - 5'd15);
		end else begin
			r15 = fold[3:0];
		end
		res.seconds = {r15, t[1:0]};
		prod = 28'(t[12:0]) * RecipSixty;
		if (t >= SatTime) begin
			res.minutes = MinW'(MinCap);
		end else begin
			res.minutes = prod[26:20];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/debounced_lap_timer.sv
// Debounced lap timer: press/query words in, one status word out per input word.
//
//  channel | handshake                     | payload
//  --------+-------------------------------+-----------------------------------------
//  in      | in_valid / in_stall           | op, now_seconds
//  out     | out_valid / out_stall         | press_accepted, running, lap_count, times
//  cfg     | cfg_valid / cfg_ready (=1)    | cfg_index, cfg_data
//
// One word per cycle while out_stall is low; a stalled output holds words back in the stages.
// Stages: input register, state update + time differences, minute/second split.
// The lap state updates as a word leaves the input register, so words see it in order.
// Each stage advances when it is empty or the stage after it advances; bubbles close up.
// Reset clears the lap state and every valid flag and loads the config registers with their reset values.
`default_nettype none
module debounced_lap_timer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic                          op,
	input  wire logic [dlt_pkg::TimeW-1:0]     now_seconds,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic                          press_accepted,
	output      logic                          running,
	output      logic [dlt_pkg::CountW-1:0]    lap_count,
	output      logic [dlt_pkg::MinW-1:0]      total_minutes,
	output      logic [dlt_pkg::SecW-1:0]      total_seconds,
	output      logic [dlt_pkg::MinW-1:0]      current_minutes,
	output      logic [dlt_pkg::SecW-1:0]      current_seconds,
	output      logic [dlt_pkg::MinW-1:0]      last_minutes,
	output      logic [dlt_pkg::SecW-1:0]      last_seconds,
	output      logic [dlt_pkg::MinW-1:0]      prior_minutes,
	output      logic [dlt_pkg::SecW-1:0]      prior_seconds,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [dlt_pkg::LimitW-1:0]    cfg_data
);

	localparam int TW = dlt_pkg::TimeW;
	localparam int CW = dlt_pkg::CountW;

	// config
	logic [dlt_pkg::LimitW-1:0] lap_limit_q;
	logic [dlt_pkg::GapW-1:0]   gap_q;

	// lap state
	logic [TW-1:0] session_q, lap_start_q, last_press_q, last_lap_q, prior_lap_q;
	logic [CW-1:0] count_q;

	// stage 1: input register
	logic          valid_s1, op_s1;
	logic [TW-1:0] now_s1;

	// stage 2: updated state and time differences
	logic          valid_s2, acc_s2, run_s2;
	logic [CW-1:0] cnt_s2;
	logic [TW-1:0] tot_s2, cur_s2, last_s2, prior_s2;

	// output register
	logic                 out_valid_q, acc_q, run_q;
	logic [CW-1:0]        cnt_q;
	dlt_pkg::split_t      tot_q, cur_q, last_q, prior_q;

	logic adv1, adv2, take1;

	// next-state logic
	logic          press;
	logic [TW-1:0] session_d, last_lap_d, prior_lap_d, lap_start_d;
	logic [CW-1:0] count_d;

	assign adv2     = !out_valid_q || !out_stall;
	assign adv1     = !valid_s2 || adv2;
	assign take1    = valid_s1 && adv1;
	assign in_stall = valid_s1 && !adv1;
	assign cfg_ready = 1'b1;

	always_comb begin
		press       = (op_s1 == dlt_pkg::OpPress) && ((now_s1 - last_press_q) > TW'(gap_q));
		session_d   = session_q;
		last_lap_d  = last_lap_q;
		prior_lap_d = prior_lap_q;
		lap_start_d = lap_start_q;
		count_d     = count_q;
		if (press) begin
			lap_start_d = now_s1;
			if (count_q > lap_limit_q) begin
				session_d   = now_s1;
				last_lap_d  = '0;
				prior_lap_d = '0;
				count_d     = '0;
			end else if (count_q == '0) begin
				session_d   = now_s1;
				last_lap_d  = '0;
				prior_lap_d = '0;
				count_d     = CW'(1);
			end else begin
				prior_lap_d = last_lap_q;
				last_lap_d  = now_s1 - lap_start_q;
				if (count_q != dlt_pkg::CountTop) begin
					count_d = count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lap_limit_q <= dlt_pkg::LimitReset;
			gap_q       <= dlt_pkg::GapReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dlt_pkg::CfgLapLimit: lap_limit_q <= cfg_data;
				dlt_pkg::CfgDebounce: gap_q <= cfg_data[dlt_pkg::GapW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q    <= '0;
			lap_start_q  <= '0;
			last_press_q <= '0;
			last_lap_q   <= '0;
			prior_lap_q  <= '0;
			count_q      <= '0;
		end else if (take1 && press) begin
			session_q    <= session_d;
			lap_start_q  <= lap_start_d;
			last_press_q <= now_s1;
			last_lap_q   <= last_lap_d;
			prior_lap_q  <= prior_lap_d;
			count_q      <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv1) begin
				valid_s2 <= valid_s1;
			end
			if (adv2) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= op;
			now_s1 <= now_seconds;
		end
		if (take1) begin
			acc_s2 <= press;
			run_s2 <= count_d != '0;
			cnt_s2 <= count_d;
			if (count_d != '0) begin
				tot_s2   <= now_s1 - session_d;
				cur_s2   <= now_s1 - lap_start_d;
				last_s2  <= last_lap_d;
				prior_s2 <= prior_lap_d;
			end else begin
				tot_s2   <= '0;
				cur_s2   <= '0;
				last_s2  <= '0;
				prior_s2 <= '0;
			end
		end
		if (valid_s2 && adv2) begin
			acc_q   <= acc_s2;
			run_q   <= run_s2;
			cnt_q   <= cnt_s2;
			tot_q   <= dlt_pkg::split_time(tot_s2);
			cur_q   <= dlt_pkg::split_time(cur_s2);
			last_q  <= dlt_pkg::split_time(last_s2);
			prior_q <= dlt_pkg::split_time(prior_s2);
		end
	end

	assign out_valid       = out_valid_q;
	assign press_accepted  = acc_q;
	assign running         = run_q;
	assign lap_count       = cnt_q;
	assign total_minutes   = tot_q.minutes;
	assign total_seconds   = tot_q.seconds;
	assign current_minutes = cur_q.minutes;
	assign current_seconds = cur_q.seconds;
	assign last_minutes    = last_q.minutes;
	assign last_seconds    = last_q.seconds;
	assign prior_minutes   = prior_q.minutes;
	assign prior_seconds   = prior_q.seconds;

	a_run_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (running == (lap_count != '0)))
		else $error("running flag disagrees with lap count");

	a_idle_times_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !running) |-> (total_minutes == '0 && total_seconds == '0 &&
		current_minutes == '0 && last_minutes == '0 && prior_seconds == '0))
		else $error("times not cleared while not running");

	a_seconds_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (total_seconds < 6'd60 && current_seconds < 6'd60 &&
		last_seconds < 6'd60 && prior_seconds < 6'd60))
		else $error("seconds field out of range");

	a_press_records_time: assert property (@(posedge clk) disable iff (!arst_n)
		(take1 && press) |=> (last_press_q == $past(now_s1) && lap_start_q == $past(now_s1)))
		else $error("accepted press did not record its time");

	a_query_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(take1 && op_s1 == dlt_pkg::OpQuery) |=>
		($stable(count_q) && $stable(session_q) && $stable(last_lap_q)))
		else $error("status query changed lap state");

endmodule
`default_nettype wire

FILE: tb/sv/debounced_lap_timer_tb.sv
// Self-checking bench for the debounced lap timer: directed, count-top, random and stall tests.
`timescale 1ns / 1ps
`default_nettype none
module debounced_lap_timer_tb;
	import dlt_pkg::*;

	localparam int CycleLimit  = 400000;
	localparam int RandomWords = 650;
	localparam int MaxReports  = 10;

	typedef struct packed {
		logic              accepted;
		logic              run;
		logic [CountW-1:0] count;
		logic [MinW-1:0]   tot_m;
		logic [SecW-1:0]   tot_s;
		logic [MinW-1:0]   cur_m;
		logic [SecW-1:0]   cur_s;
		logic [MinW-1:0]   last_m;
		logic [SecW-1:0]   last_s;
		logic [MinW-1:0]   pri_m;
		logic [SecW-1:0]   pri_s;
	} status_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               op          = OpQuery;
	logic [TimeW-1:0]   now_seconds = '0;
	logic               out_stall   = 1'b0;
	logic               cfg_valid   = 1'b0;
	logic               cfg_index   = CfgLapLimit;
	logic [LimitW-1:0]  cfg_data    = '0;
	logic               in_stall;
	logic               out_valid;
	logic               press_accepted;
	logic               running;
	logic [CountW-1:0]  lap_count;
	logic [MinW-1:0]    total_minutes;
	logic [SecW-1:0]    total_seconds;
	logic [MinW-1:0]    current_minutes;
	logic [SecW-1:0]    current_seconds;
	logic [MinW-1:0]    last_minutes;
	logic [SecW-1:0]    last_seconds;
	logic [MinW-1:0]    prior_minutes;
	logic [SecW-1:0]    prior_seconds;
	logic               cfg_ready;

	debounced_lap_timer u_top (.*);

	// lap timer model state
	logic [TimeW-1:0]   ses_start;
	logic [TimeW-1:0]   lap_begin;
	logic [TimeW-1:0]   last_press;
	logic [CountW-1:0]  laps;
	logic [TimeW-1:0]   last_lap;
	logic [TimeW-1:0]   prior_lap;
	logic [LimitW-1:0]  cfg_lim;
	logic [GapW-1:0]    cfg_gap;

	status_t            status_q[$];
	int                 mismatches  = 0;
	int                 cycles      = 0;
	int                 hold_req    = 0;
	int                 hold_left   = 0;
	bit                 in_idle_en  = 1'b1;
	bit                 out_idle_en = 1'b1;
	logic [TimeW-1:0]   clock_now;

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [MinW+SecW-1:0] min_sec(input logic [TimeW-1:0] t);
		logic [TimeW-1:0] m;
		m = t / SecPerMin;
		if (m > MinCap)
			m = MinCap;
		return {m[MinW-1:0], SecW'(t % SecPerMin)};
	endfunction

	function automatic status_t next_status(input logic o, input logic [TimeW-1:0] t);
		status_t s;
		logic [TimeW-1:0] d;
		s = '0;
		d = t - last_press;
		if (o == OpPress && d > {{(TimeW-GapW){1'b0}}, cfg_gap}) begin
			s.accepted = 1'b1;
			last_press = t;
			if (laps > cfg_lim) begin
				ses_start = t;
				last_lap  = '0;
				prior_lap = '0;
				laps      = '0;
			end else if (laps == '0) begin
				ses_start = t;
				last_lap  = '0;
				prior_lap = '0;
				laps      = CountW'(1);
			end else begin
				prior_lap = last_lap;
				last_lap  = t - lap_begin;
				if (laps != CountTop)
					laps = laps + CountW'(1);
			end
			lap_begin = t;
		end
		s.run   = (laps != '0);
		s.count = laps;
		if (laps != '0) begin
			{s.tot_m, s.tot_s}   = min_sec(t - ses_start);
			{s.cur_m, s.cur_s}   = min_sec(t - lap_begin);
			{s.last_m, s.last_s} = min_sec(last_lap);
			{s.pri_m, s.pri_s}   = min_sec(prior_lap);
		end
		return s;
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MaxReports)
				$display("mismatch %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
		end
	endtask

	// output words are stable from the previous edge; taken at the next one
	always @(negedge clk) begin
		status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("mismatch: unexpected output word at %0t", $realtime);
			end else begin
				want = status_q.pop_front();
				compare_field("press_accepted", int'(want.accepted), int'(press_accepted));
				compare_field("running", int'(want.run), int'(running));
				compare_field("lap_count", int'(want.count), int'(lap_count));
				compare_field("total_minutes", int'(want.tot_m), int'(total_minutes));
				compare_field("total_seconds", int'(want.tot_s), int'(total_seconds));
				compare_field("current_minutes", int'(want.cur_m), int'(current_minutes));
				compare_field("current_seconds", int'(want.cur_s), int'(current_seconds));
				compare_field("last_minutes", int'(want.last_m), int'(last_minutes));
				compare_field("last_seconds", int'(want.last_s), int'(last_seconds));
				compare_field("prior_minutes", int'(want.pri_m), int'(prior_minutes));
				compare_field("prior_seconds", int'(want.pri_s), int'(prior_seconds));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= out_idle_en && ($urandom_range(99) < 31);
		end
	end

	task automatic send_word(input logic o, input logic [TimeW-1:0] t);
		logic ok;
		if (in_idle_en) begin
			while ($urandom_range(99) < 31) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		op          <= o;
		now_seconds <= t;
		do begin
			@(negedge clk);
			ok = !in_stall;
			@(posedge clk);
		end while (!ok);
		status_q.push_back(next_status(o, t));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (status_q.size() != 0);
	endtask

	task automatic write_regs(input logic [LimitW-1:0] limit, input logic [GapW-1:0] gap);
		logic ok;
		cfg_valid <= 1'b1;
		cfg_index <= CfgLapLimit;
		cfg_data  <= limit;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_lim = limit;
		cfg_index <= CfgDebounce;
		cfg_data  <= {1'($urandom_range(1)), gap};
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_gap = gap;
		cfg_valid <= 1'b0;
	endtask

	task automatic step_clock();
		int r;
		r = $urandom_range(99);
		if (r < 2)
			clock_now = $urandom;
		else if (r < 4)
			clock_now = clock_now - $urandom_range(1, 5000);
		else if (r < 12)
			clock_now = clock_now + $urandom_range(60, 7000);
		else
			clock_now = clock_now + $urandom_range(0, 25);
	endtask

	task automatic test_directed();
		send_word(OpQuery, 0);
		send_word(OpPress, 0);
		send_word(OpPress, 2);
		send_word(OpPress, 3);
		send_word(OpPress, 65);
		send_word(OpPress, 6200);
		send_word(OpQuery, 32'hFFFF_FFFF);
		send_word(OpPress, 32'hFFFF_FFFF);
		send_word(OpPress, 5);
		send_word(OpQuery, 32'hAAAA_5555);
		drain();
		write_regs(0, 0);
		send_word(OpPress, 5);
		send_word(OpPress, 6);
		send_word(OpQuery, 7);
		send_word(OpPress, 8);
		send_word(OpPress, 9);
		drain();
		write_regs(30, 15);
		send_word(OpPress, 24);
		send_word(OpPress, 25);
		send_word(OpPress, 32'h5555_AAAA);
		send_word(OpQuery, 32'h5555_AAAB);
		clock_now = 32'h5555_AAAB;
		drain();
	endtask

	// lap count pinned at its top, then cleared by a low limit
	task automatic test_count_top();
		write_regs(31, 0);
		repeat (36) begin
			clock_now = clock_now + $urandom_range(1, 90);
			send_word(OpPress, clock_now);
		end
		drain();
		write_regs(1, 0);
		repeat (3) begin
			clock_now = clock_now + $urandom_range(1, 90);
			send_word(OpPress, clock_now);
		end
		drain();
	endtask

	task automatic test_random();
		logic [LimitW-1:0] lim;
		logic [GapW-1:0]   gap;
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin lim = 1;  gap = 0; end
				1: begin lim = 30; gap = 15; end
				2: begin
					lim = LimitW'($urandom_range(0, 31));
					gap = GapW'($urandom_range(0, 15));
				end
				3: begin lim = 31; gap = GapW'($urandom_range(0, 15)); end
				default: begin lim = 0; gap = 1; end
			endcase
			in_idle_en  = (p != 4);
			out_idle_en = (p != 4);
			write_regs(lim, gap);
			repeat (RandomWords / 5) begin
				step_clock();
				send_word(($urandom_range(99) < 25) ? OpQuery : OpPress, clock_now);
			end
			drain();
		end
		in_idle_en  = 1'b1;
		out_idle_en = 1'b1;
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_backpressure();
		write_regs(LimitReset, GapReset);
		in_idle_en = 1'b0;
		hold_req   = 400;
		repeat (40) begin
			clock_now = clock_now + $urandom_range(0, 4);
			send_word(($urandom_range(99) < 20) ? OpQuery : OpPress, clock_now);
		end
		drain();
		in_idle_en = 1'b1;
	endtask

	initial begin
		ses_start  = '0;
		lap_begin  = '0;
		last_press = '0;
		laps       = '0;
		last_lap   = '0;
		prior_lap  = '0;
		cfg_lim    = LimitReset;
		cfg_gap    = GapReset;
		clock_now  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_count_top();
		test_random();
		test_backpressure();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && status_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
